### design/vrl_pkg.sv
// shared types and constants for the velocity ramp limiter
`default_nettype none

package vrl_pkg;

    // field widths
    localparam int unsigned VEL_W   = 18;
    localparam int unsigned RATE_W  = 16;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned SLF_W   = 17;
    localparam int unsigned SLR_W   = 18;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned REACH_W = RATE_W + TIME_W;
    localparam int unsigned FULL_W  = VEL_W + TIME_W;
    localparam int unsigned CNT_W   = 4;

    // register reset values
    localparam logic [RATE_W-1:0] RST_ACCEL_FWD = 16'd1000;
    localparam logic [RATE_W-1:0] RST_ACCEL_REV = 16'd1000;
    localparam logic [RATE_W-1:0] RST_DECEL_FWD = 16'd1000;
    localparam logic [RATE_W-1:0] RST_DECEL_REV = 16'd1000;
    localparam logic [SLF_W-1:0]  RST_SPEED_FWD = 17'd10000;
    localparam logic [SLR_W-1:0]  RST_SPEED_REV = 18'd5000;
    localparam logic [TIME_W-1:0] RST_TICK      = 16'd3277;

    // register map, word index
    typedef enum logic [2:0] {
        REG_ACCEL_FWD = 3'd0,
        REG_ACCEL_REV = 3'd1,
        REG_DECEL_FWD = 3'd2,
        REG_DECEL_REV = 3'd3,
        REG_SPEED_FWD = 3'd4,
        REG_SPEED_REV = 3'd5,
        REG_TICK      = 3'd6
    } t_reg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_NEXT,
        ST_CLAMP,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### design/velocity_ramp_limiter.sv
// top level of the velocity ramp limiter: registers, sequencer and shared divide step
//
//  port group   | direction | handshake            | payload
//  -------------+-----------+----------------------+-------------------------------
//  target in    | in        | i_valid / o_ready    | i_target_velocity (18 s)
//  velocity out | out       | o_valid / i_ready    | o_new_velocity (18 s)
//  apb config   | in/out    | psel, penable/pready | paddr, pwdata, prdata (32)
//
// each leg of a word passes the rate, multiply and compare states, plus the divide when the
// leg reaches its target with a nonzero rate; a word also passes entry, clamp and hand-off.
// the 16-step restoring divider (one quotient bit per cycle) sets the long path.
// i_rst_n is synchronous: it clears the sequencer, the stored velocity, the output
// valid and the registers to their defaults. o_ready is high only while idle; a
// finished word waits in the output register while the next target is taken.
`default_nettype none

module velocity_ramp_limiter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // target channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [vrl_pkg::VEL_W-1:0]  i_target_velocity,
    // velocity channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [vrl_pkg::VEL_W-1:0]       o_new_velocity,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [vrl_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [vrl_pkg::DATA_W-1:0]        pwdata,
    output logic [vrl_pkg::DATA_W-1:0]             prdata,
    output logic                                   pready
);

    localparam int unsigned VW = vrl_pkg::VEL_W;
    localparam int unsigned RW = vrl_pkg::RATE_W;
    localparam int unsigned TW = vrl_pkg::TIME_W;

    // configuration registers
    logic [RW-1:0]              r_accel_fwd;
    logic [RW-1:0]              r_accel_rev;
    logic [RW-1:0]              r_decel_fwd;
    logic [RW-1:0]              r_decel_rev;
    logic [vrl_pkg::SLF_W-1:0]  r_speed_fwd;
    logic [vrl_pkg::SLR_W-1:0]  r_speed_rev;
    logic [TW-1:0]              r_tick;

    // sequencer and datapath registers
    vrl_pkg::t_state            r_state, n_state;
    logic signed [VW-1:0]       r_cur;
    logic signed [VW-1:0]       r_v;
    logic signed [VW-1:0]       r_target;
    logic signed [VW-1:0]       r_leg_tgt;
    logic                       r_flip;
    logic                       r_leg2;
    logic [TW-1:0]              r_t;
    logic [RW-1:0]              r_a;
    logic [VW-1:0]              r_d;
    logic [vrl_pkg::REACH_W-1:0] r_reach;
    logic [RW-1:0]              r_rem;
    logic [TW-1:0]              r_q;
    logic [vrl_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_out_valid;
    logic signed [VW-1:0]       r_out;

    // control decode
    logic w_in_acc;
    logic w_out_acc;
    logic w_cfg_wr;
    logic w_done_go;

    // apb register access
    vrl_pkg::t_reg_idx w_idx;
    assign w_idx    = vrl_pkg::t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr = psel & penable & pwrite;
    assign pready   = 1'b1;

    always_comb begin
        case (w_idx)
            vrl_pkg::REG_ACCEL_FWD: prdata = {16'd0, r_accel_fwd};
            vrl_pkg::REG_ACCEL_REV: prdata = {16'd0, r_accel_rev};
            vrl_pkg::REG_DECEL_FWD: prdata = {16'd0, r_decel_fwd};
            vrl_pkg::REG_DECEL_REV: prdata = {16'd0, r_decel_rev};
            vrl_pkg::REG_SPEED_FWD: prdata = {15'd0, r_speed_fwd};
            vrl_pkg::REG_SPEED_REV: prdata = {14'd0, r_speed_rev};
            vrl_pkg::REG_TICK:      prdata = {16'd0, r_tick};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_fwd <= vrl_pkg::RST_ACCEL_FWD;
            r_accel_rev <= vrl_pkg::RST_ACCEL_REV;
            r_decel_fwd <= vrl_pkg::RST_DECEL_FWD;
            r_decel_rev <= vrl_pkg::RST_DECEL_REV;
            r_speed_fwd <= vrl_pkg::RST_SPEED_FWD;
            r_speed_rev <= vrl_pkg::RST_SPEED_REV;
            r_tick      <= vrl_pkg::RST_TICK;
        end else if (w_cfg_wr) begin
            case (w_idx)
                vrl_pkg::REG_ACCEL_FWD: r_accel_fwd <= pwdata[RW-1:0];
                vrl_pkg::REG_ACCEL_REV: r_accel_rev <= pwdata[RW-1:0];
                vrl_pkg::REG_DECEL_FWD: r_decel_fwd <= pwdata[RW-1:0];
                vrl_pkg::REG_DECEL_REV: r_decel_rev <= pwdata[RW-1:0];
                vrl_pkg::REG_SPEED_FWD: r_speed_fwd <= pwdata[vrl_pkg::SLF_W-1:0];
                vrl_pkg::REG_SPEED_REV: r_speed_rev <= pwdata[vrl_pkg::SLR_W-1:0];
                vrl_pkg::REG_TICK:      r_tick      <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // leg setup: rate choice and distance
    logic [VW-1:0]        w_abs_v;
    logic [VW-1:0]        w_abs_tgt;
    logic signed [VW:0]   w_diff;
    logic [VW:0]          w_abs_diff;
    logic [RW-1:0]        w_rate;

    assign w_abs_v    = r_v[VW-1] ? VW'(-r_v) : VW'(r_v);
    assign w_abs_tgt  = r_leg_tgt[VW-1] ? VW'(-r_leg_tgt) : VW'(r_leg_tgt);
    assign w_diff     = {r_leg_tgt[VW-1], r_leg_tgt} - {r_v[VW-1], r_v};
    assign w_abs_diff = w_diff[VW] ? (VW+1)'(-w_diff) : (VW+1)'(w_diff);

    always_comb begin
        if (w_abs_tgt > w_abs_v) begin
            w_rate = r_leg_tgt[VW-1] ? r_accel_rev : r_accel_fwd;
        end else begin
            w_rate = r_leg_tgt[VW-1] ? r_decel_rev : r_decel_fwd;
        end
    end

    // reach test and partial step
    logic                 w_reached;
    logic [TW-1:0]        w_step;
    logic signed [VW:0]   w_moved;

    assign w_reached = {2'b00, r_reach} >= {r_d, {TW{1'b0}}};
    assign w_step    = r_reach[vrl_pkg::REACH_W-1:TW];
    always_comb begin
        if (r_v < r_leg_tgt) begin
            w_moved = {r_v[VW-1], r_v} + $signed({3'b000, w_step});
        end else begin
            w_moved = {r_v[VW-1], r_v} - $signed({3'b000, w_step});
        end
    end

    // shared divide step: one quotient bit per cycle
    logic [RW:0] w_rem2;
    logic        w_ge;
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_a};

    // speed clamp
    logic signed [VW+1:0] w_v_ext;
    logic signed [VW+1:0] w_lim_fwd;
    logic signed [VW+1:0] w_lim_rev;
    logic signed [VW+1:0] w_clamped;

    assign w_v_ext   = {{2{r_v[VW-1]}}, r_v};
    assign w_lim_fwd = $signed({3'b000, r_speed_fwd});
    assign w_lim_rev = -$signed({2'b00, r_speed_rev});
    always_comb begin
        w_clamped = w_v_ext;
        if (w_v_ext > w_lim_fwd) begin
            w_clamped = w_lim_fwd;
        end
        if (w_v_ext < w_lim_rev) begin
            w_clamped = w_lim_rev;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vrl_pkg::ST_IDLE:  if (i_valid) n_state = vrl_pkg::ST_RATE;
            vrl_pkg::ST_RATE:  n_state = vrl_pkg::ST_MUL;
            vrl_pkg::ST_MUL:   n_state = vrl_pkg::ST_CMP;
            vrl_pkg::ST_CMP: begin
                if (w_reached && (r_a != '0)) begin
                    n_state = vrl_pkg::ST_DIV;
                end else begin
                    n_state = vrl_pkg::ST_NEXT;
                end
            end
            vrl_pkg::ST_DIV: begin
                if (r_cnt == '1) n_state = vrl_pkg::ST_NEXT;
            end
            vrl_pkg::ST_NEXT: begin
                if (r_flip && !r_leg2) begin
                    n_state = vrl_pkg::ST_RATE;
                end else begin
                    n_state = vrl_pkg::ST_CLAMP;
                end
            end
            vrl_pkg::ST_CLAMP: n_state = vrl_pkg::ST_DONE;
            vrl_pkg::ST_DONE:  if (w_done_go) n_state = vrl_pkg::ST_IDLE;
            default:           n_state = vrl_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready   = (r_state == vrl_pkg::ST_IDLE);
        w_done_go = (r_state == vrl_pkg::ST_DONE) && (!r_out_valid || i_ready);
    end

    assign w_in_acc       = i_valid & o_ready;
    assign w_out_acc      = r_out_valid & i_ready;
    assign o_valid        = r_out_valid;
    assign o_new_velocity = r_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vrl_pkg::ST_IDLE;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done_go) begin
                r_cur       <= r_v;
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            vrl_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    r_target  <= i_target_velocity;
                    r_v       <= r_cur;
                    r_flip    <= i_target_velocity[VW-1] != r_cur[VW-1];
                    r_leg_tgt <= (i_target_velocity[VW-1] != r_cur[VW-1])
                                 ? '0 : i_target_velocity;
                    r_t       <= r_tick;
                    r_leg2    <= 1'b0;
                end
            end
            vrl_pkg::ST_RATE: begin
                r_a <= w_rate;
                r_d <= w_abs_diff[VW-1:0];
            end
            vrl_pkg::ST_MUL: begin
                r_reach <= r_a * r_t;
            end
            vrl_pkg::ST_CMP: begin
                r_q   <= '0;
                r_cnt <= '0;
                r_rem <= r_d[RW-1:0];
                if (w_reached) begin
                    r_v <= r_leg_tgt;
                end else begin
                    r_v <= w_moved[VW-1:0];
                    r_t <= '0;
                end
            end
            vrl_pkg::ST_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                if (w_ge) begin
                    r_rem <= RW'(w_rem2 - {1'b0, r_a});
                    r_q   <= {r_q[TW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[RW-1:0];
                    r_q   <= {r_q[TW-2:0], 1'b0};
                end
            end
            vrl_pkg::ST_NEXT: begin
                r_t       <= r_t - r_q;
                r_leg2    <= 1'b1;
                r_leg_tgt <= r_target;
            end
            vrl_pkg::ST_CLAMP: begin
                r_v <= w_clamped[VW-1:0];
            end
            vrl_pkg::ST_DONE: begin
                if (w_done_go) r_out <= r_v;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### design/vrl_checker.sv
// port-level checks for the velocity ramp limiter, bound to the top level
`default_nettype none

module vrl_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_valid,
    input wire logic                             o_ready,
    input wire logic                             o_valid,
    input wire logic                             i_ready,
    input wire logic signed [vrl_pkg::VEL_W-1:0] o_new_velocity,
    input wire logic                             pready
);

    // the config port never stalls
    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    // a waiting word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_new_velocity)))
        else $error("output word changed while stalled");

    // the block is busy after taking a target
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after accept");

    // a new result is valid whenever the sequencer returns to idle
    a_result_with_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && $past(i_rst_n) && $rose(o_ready)) |-> 1'b0)
        else $error("returned to idle without a result");

endmodule

bind velocity_ramp_limiter vrl_checker u_vrl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_new_velocity (o_new_velocity),
    .pready         (pready)
);

`default_nettype wire

### dv/velocity_ramp_limiter_checker.sv
`timescale 1ns / 1ps
// checker for the velocity ramp limiter: register snoop, velocity prediction and word compare
module velocity_ramp_limiter_checker
    import vrl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // target channel
    input  logic                     i_tgt_valid,
    input  logic                     i_tgt_ready,
    input  logic signed [VEL_W-1:0]  i_target_velocity,
    // velocity channel
    input  logic                     i_vel_valid,
    input  logic                     i_vel_ready,
    input  logic signed [VEL_W-1:0]  i_new_velocity,
    // configuration port
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic                     i_pready,
    input  logic [ADDR_W-1:0]        i_paddr,
    input  logic [DATA_W-1:0]        i_pwdata,
    // status toward the testbench top
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef logic signed [VEL_W-1:0] t_vel;

    // shadow copy of the registers
    logic [RATE_W-1:0] accel_fwd;
    logic [RATE_W-1:0] accel_rev;
    logic [RATE_W-1:0] decel_fwd;
    logic [RATE_W-1:0] decel_rev;
    logic [SLF_W-1:0]  speed_fwd;
    logic [SLR_W-1:0]  speed_rev;
    logic [TIME_W-1:0] tick;

    // stored velocity and the words still owed by the block
    t_vel cur_vel;
    t_vel pending_velocity[$];
    int   fail_count    = 0;
    int   pending_words = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_words;

    // one leg toward goal within budget; returns the time left over
    function automatic longint unsigned ramp_leg(inout longint vel, input longint goal,
                                                 input longint unsigned budget);
        longint unsigned rate;
        longint unsigned span;
        longint unsigned full;
        longint unsigned reach;
        longint unsigned used;
        longint          mag_goal;
        longint          mag_vel;
        mag_goal = (goal < 0) ? -goal : goal;
        mag_vel  = (vel < 0) ? -vel : vel;
        // speed magnitude growing means accelerate, else decelerate
        if (mag_goal > mag_vel)
            rate = (goal >= 0) ? longint'(accel_fwd) : longint'(accel_rev);
        else
            rate = (goal >= 0) ? longint'(decel_fwd) : longint'(decel_rev);
        span  = (goal > vel) ? goal - vel : vel - goal;
        full  = span << 16;
        reach = rate * budget;
        if (reach >= full) begin
            used = (rate != 0) ? full / rate : 0;
            vel  = goal;
            return (used <= budget) ? budget - used : 0;
        end
        if (vel < goal)
            vel = vel + longint'(reach >> 16);
        else
            vel = vel - longint'(reach >> 16);
        return 0;
    endfunction

    // next stored velocity for one target; updates the shadow state
    function automatic t_vel advance_velocity(input t_vel target);
        longint          goal;
        longint          vel;
        longint          lim_fwd;
        longint          lim_rev;
        longint unsigned rest;
        bit              flip;
        goal    = longint'(target);
        vel     = longint'(cur_vel);
        lim_fwd = longint'(speed_fwd);
        lim_rev = longint'(speed_rev);
        flip    = (goal >= 0) != (vel >= 0);
        // a sign change ramps to zero first, the leftover time goes on to the target
        rest = ramp_leg(vel, flip ? 0 : goal, longint'(tick));
        if (flip)
            void'(ramp_leg(vel, goal, rest));
        if (vel > lim_fwd)
            vel = lim_fwd;
        if (vel < -lim_rev)
            vel = -lim_rev;
        cur_vel = t_vel'(vel);
        return cur_vel;
    endfunction

    always @(posedge i_clk) begin
        t_vel want;
        if (!i_rst_n) begin
            accel_fwd = RST_ACCEL_FWD;
            accel_rev = RST_ACCEL_REV;
            decel_fwd = RST_DECEL_FWD;
            decel_rev = RST_DECEL_REV;
            speed_fwd = RST_SPEED_FWD;
            speed_rev = RST_SPEED_REV;
            tick      = RST_TICK;
            cur_vel   = '0;
            pending_velocity.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_ACCEL_FWD: accel_fwd = i_pwdata[RATE_W-1:0];
                    REG_ACCEL_REV: accel_rev = i_pwdata[RATE_W-1:0];
                    REG_DECEL_FWD: decel_fwd = i_pwdata[RATE_W-1:0];
                    REG_DECEL_REV: decel_rev = i_pwdata[RATE_W-1:0];
                    REG_SPEED_FWD: speed_fwd = i_pwdata[SLF_W-1:0];
                    REG_SPEED_REV: speed_rev = i_pwdata[SLR_W-1:0];
                    REG_TICK:      tick      = i_pwdata[TIME_W-1:0];
                    default: ;
                endcase
            end
            // compare each delivered word with the oldest prediction
            if (i_vel_valid && i_vel_ready) begin
                if (pending_velocity.size() == 0) begin
                    $error("new_velocity: expected no word, got %0d", i_new_velocity);
                    fail_count++;
                end else begin
                    want = pending_velocity.pop_front();
                    if (i_new_velocity !== want) begin
                        $error("new_velocity mismatch: expected %0d, got %0d",
                               want, i_new_velocity);
                        fail_count++;
                    end
                end
            end
            // predict the word for each accepted target
            if (i_tgt_valid && i_tgt_ready)
                pending_velocity.push_back(advance_velocity(i_target_velocity));
        end
        pending_words = pending_velocity.size();
    end

endmodule

### dv/velocity_ramp_limiter_tb.sv
`timescale 1ns / 1ps
// testbench top for the velocity ramp limiter: clock, reset, stimulus and verdict
module velocity_ramp_limiter_tb;
    import vrl_pkg::*;

    typedef logic signed [VEL_W-1:0] t_vel;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 90;
    localparam int DRAIN_CYCLES  = 60;

    logic              clk;
    logic              rst_n;
    logic              tgt_valid;
    logic              tgt_ready;
    t_vel              tgt_velocity;
    logic              vel_valid;
    logic              vel_ready;
    t_vel              new_velocity;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   fail_count;
    int   pending_words;
    int   idle_cycles = 0;
    bit   quiet;
    bit   hold_off;
    int   run_left;
    t_vel run_target;

    velocity_ramp_limiter u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (tgt_valid),
        .o_ready           (tgt_ready),
        .i_target_velocity (tgt_velocity),
        .o_valid           (vel_valid),
        .i_ready           (vel_ready),
        .o_new_velocity    (new_velocity),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    velocity_ramp_limiter_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_tgt_valid       (tgt_valid),
        .i_tgt_ready       (tgt_ready),
        .i_target_velocity (tgt_velocity),
        .i_vel_valid       (vel_valid),
        .i_vel_ready       (vel_ready),
        .i_new_velocity    (new_velocity),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending_words)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog on cycles with no word and no register access
    always @(posedge clk) begin
        if ((tgt_valid && tgt_ready) || (vel_valid && vel_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // velocity receiver: random stalls plus one long hold-off on request
    initial begin
        int stall;
        vel_ready = 1'b0;
        forever begin
            if (hold_off) begin
                vel_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            stall = quiet ? 0 : $urandom_range(7, 0);
            if (stall != 0) begin
                vel_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            vel_ready = 1'b1;
            do @(posedge clk); while (!vel_valid);
            @(negedge clk);
        end
    end

    // offer one target word, called and returning at a falling edge
    task automatic offer_target(input int value);
        int gap;
        gap = quiet ? 0 : $urandom_range(7, 0);
        if (gap != 0) begin
            tgt_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tgt_valid    = 1'b1;
        tgt_velocity = t_vel'(value);
        do @(posedge clk); while (!tgt_ready);
        @(negedge clk);
    endtask

    // stop offering and wait for every owed word
    task automatic settle();
        tgt_valid = 1'b0;
        wait (pending_words == 0);
        @(negedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic program_regs(input logic [DATA_W-1:0] af, input logic [DATA_W-1:0] ar,
                                input logic [DATA_W-1:0] df, input logic [DATA_W-1:0] dr,
                                input logic [DATA_W-1:0] sf, input logic [DATA_W-1:0] sr,
                                input logic [DATA_W-1:0] tk);
        write_reg(REG_ACCEL_FWD, af);
        write_reg(REG_ACCEL_REV, ar);
        write_reg(REG_DECEL_FWD, df);
        write_reg(REG_DECEL_REV, dr);
        write_reg(REG_SPEED_FWD, sf);
        write_reg(REG_SPEED_REV, sr);
        write_reg(REG_TICK, tk);
    endtask

    // rate draw: mostly spread over decades, now and then zero or the top value
    function automatic logic [DATA_W-1:0] draw_rate();
        int sel;
        sel = $urandom_range(15, 0);
        if (sel == 0)
            return 0;
        if (sel < 5)
            return $urandom_range(300, 1);
        if (sel < 10)
            return $urandom_range(8000, 300);
        if (sel < 15)
            return $urandom_range(65535, 8000);
        return 65535;
    endfunction

    function automatic logic [DATA_W-1:0] draw_tick();
        int sel;
        sel = $urandom_range(15, 0);
        if (sel == 0)
            return 0;
        if (sel < 4)
            return $urandom_range(2000, 1);
        if (sel < 12)
            return $urandom_range(20000, 2000);
        return $urandom_range(65535, 20000);
    endfunction

    function automatic logic [DATA_W-1:0] draw_limit(input bit reverse);
        int sel;
        sel = $urandom_range(15, 0);
        if (sel < 2)
            return $urandom_range(2000, 0);
        if (sel == 15)
            return reverse ? $urandom_range(262143, 131072) : 131071;
        return reverse ? $urandom_range(131072, 30000) : $urandom_range(131071, 30000);
    endfunction

    // targets come in runs so the velocity can settle, with some one-off noise
    function automatic t_vel draw_target();
        int sel;
        int k;
        if ($urandom_range(7, 0) == 0)
            return t_vel'($urandom());
        if (run_left == 0) begin
            sel = $urandom_range(15, 0);
            if (sel < 6) begin
                run_target = t_vel'($urandom());
            end else if (sel < 9) begin
                k = $urandom_range(6000, 0);
                run_target = t_vel'(k - 3000);
            end else if (sel < 11) begin
                case ($urandom_range(2, 0))
                    0:       run_target = t_vel'(-131072);
                    1:       run_target = t_vel'(131071);
                    default: run_target = '0;
                endcase
            end else begin
                k = $urandom_range(120000, 0);
                run_target = t_vel'(k - 60000);
            end
            run_left = $urandom_range(6, 1);
        end
        run_left--;
        return run_target;
    endfunction

    task automatic run_targets(input int count, input bit with_hold);
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 3)
                hold_off = 1'b1;
            offer_target(int'(draw_target()));
        end
    endtask

    // stimulus and verdict
    initial begin
        rst_n        = 1'b0;
        tgt_valid    = 1'b0;
        tgt_velocity = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        quiet        = 1'b0;
        hold_off     = 1'b0;
        run_left     = 0;
        run_target   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: a flip that just reaches zero, zero target from negative
        offer_target(0);
        offer_target(131071);
        offer_target(131071);
        offer_target(20);
        offer_target(-1);
        offer_target(-131072);
        offer_target(0);
        offer_target(7);
        settle();

        // every register but the reverse speed limit at its top value: full swings and second legs
        program_regs(65535, 65535, 65535, 65535, 131071, 131072, 65535);
        offer_target(131071);
        offer_target(-131072);
        offer_target(-131072);
        offer_target(131071);
        offer_target(0);
        offer_target(-1);
        offer_target(1);
        offer_target(0);
        settle();

        // smallest rates and tick, both speed limits at zero
        program_regs(1, 1, 1, 1, 0, 0, 1);
        offer_target(100);
        offer_target(-100);
        offer_target(0);
        settle();

        // two rates at zero, zero tick, reverse limit beyond the velocity range
        program_regs(0, 40000, 30000, 0, 1000, 262143, 0);
        offer_target(5000);
        offer_target(-5000);
        settle();
        write_reg(REG_TICK, 30000);
        offer_target(5000);
        offer_target(-5000);
        offer_target(0);
        offer_target(-131072);
        offer_target(-131072);
        offer_target(131071);

        // random settings, one long receiver hold-off in the third phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            program_regs(draw_rate(), draw_rate(), draw_rate(), draw_rate(),
                         draw_limit(1'b0), draw_limit(1'b1), draw_tick());
            quiet = ($urandom_range(3, 0) == 0);
            run_targets(PHASE_WORDS, ph == 2);
        end
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### velocity_ramp_limiter.f
design/vrl_pkg.sv
design/velocity_ramp_limiter.sv
design/vrl_checker.sv
dv/velocity_ramp_limiter_checker.sv
dv/velocity_ramp_limiter_tb.sv
